@@ hdl/coc_pkg.sv @@
// ----------------------------------------------------------------------------
// Circle obstacle cost classifier package
// Shared widths, codes, cost values and the command and result records that
// pass between the front end, the command queue and the scan back end.
// ----------------------------------------------------------------------------
package coc_pkg;

    // Design sizes.
    localparam int MAX_OBSTACLES_DEF = 8;
    localparam int GRID_DIM          = 256;
    localparam int FRAC_BITS         = 6;

    // Field widths.
    localparam int CW        = 18;
    localparam int RW        = 16;
    localparam int CELLW     = 8;
    localparam int SLOTW     = 3;
    localparam int COUNTW    = 4;
    localparam int DIMW      = 9;
    localparam int COSTW     = 8;
    localparam int CFG_IDXW  = 2;
    localparam int CFG_DATAW = 9;

    // Datapath widths: box edges, offsets, squares and their sum.
    localparam int BW  = CW + 1;
    localparam int DXW = CW + 2;
    localparam int SQW = 2 * DXW;
    localparam int D2W = SQW + 1;

    // Register reset values.
    localparam logic [COUNTW-1:0] COUNT_RESET = '0;
    localparam logic [DIMW-1:0]   GRID_RESET  = DIMW'(200);

    // Cost codes.
    localparam logic signed [COSTW-1:0] COST_LETHAL  = COSTW'(100);
    localparam logic signed [COSTW-1:0] COST_MARGIN  = COSTW'(50);
    localparam logic signed [COSTW-1:0] COST_UNKNOWN = COSTW'(-1);

    typedef enum logic {
        OP_WRITE    = 1'b0,
        OP_CLASSIFY = 1'b1
    } t_op;

    typedef enum logic [CFG_IDXW-1:0] {
        CFG_COUNT  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DRAIN,
        B_OUT
    } t_bstate;

    typedef struct packed {
        logic signed [CW-1:0] center_col;
        logic signed [CW-1:0] center_row;
        logic [RW-1:0]        radius;
        logic [RW-1:0]        clearance;
    } t_obst;

    localparam int OBSTW = $bits(t_obst);

    typedef struct packed {
        t_op              op;
        logic             slot_ok;
        logic [SLOTW-1:0] slot;
        t_obst            obst;
        logic [CELLW-1:0] col;
        logic [CELLW-1:0] row;
        logic             outside;
    } t_cmd;

    typedef struct packed {
        logic                    valid;
        logic signed [COSTW-1:0] cost;
        logic                    outside;
    } t_res;

endpackage

@@ hdl/circle_obstacle_cost_classifier_core.sv @@
// ----------------------------------------------------------------------------
// Circle obstacle cost classifier core
// Keeps a table of circular obstacles and returns the cost of map cells.
//
//   Channel   Handshake              Payload
//   input     push / full            operation, slot, center, radius, cell
//   result    empty / pop            cost, outside_map
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A table write completes as the back end pops it; a cell outside the map or a
// query with no obstacles goes straight to the result; a query inside the map
// scans obstacle_count slots (count clamped to the table size), reading one
// table slot a cycle from the obstacle RAM through the four-stage test
// pipeline behind it, and then hands over the result.
// The input queue keeps taking items, while it has room, while a result waits to be popped.
// Reset is synchronous; it empties the queues and loads the register
// defaults. The table itself has no reset.
// ----------------------------------------------------------------------------
module circle_obstacle_cost_classifier_core #(
    parameter int MAX_OBSTACLES = coc_pkg::MAX_OBSTACLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_operation,
    input  logic [coc_pkg::SLOTW-1:0]         i_slot,
    input  logic signed [coc_pkg::CW-1:0]     i_center_col,
    input  logic signed [coc_pkg::CW-1:0]     i_center_row,
    input  logic [coc_pkg::RW-1:0]            i_radius,
    input  logic [coc_pkg::RW-1:0]            i_clearance,
    input  logic [coc_pkg::CELLW-1:0]         i_cell_col,
    input  logic [coc_pkg::CELLW-1:0]         i_cell_row,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [coc_pkg::COSTW-1:0]  o_cost,
    output logic                              o_outside_map,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [coc_pkg::CFG_IDXW-1:0]      i_cfg_index,
    input  logic [coc_pkg::CFG_DATAW-1:0]     i_cfg_data
);
    import coc_pkg::*;

    logic [COUNTW-1:0]       r_count;
    logic [DIMW-1:0]         r_width;
    logic [DIMW-1:0]         r_height;

    logic                    w_q_full;
    logic                    w_q_push;
    logic                    w_q_empty;
    logic                    w_q_pop;
    t_cmd                    w_cmd_in;
    t_cmd                    w_cmd_out;
    t_res                    w_res;
    logic                    w_res_ready;

    logic                    r_out_vld;
    logic signed [COSTW-1:0] r_out_cost;
    logic                    r_out_outside;

    // Configuration registers; every transfer is taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= COUNT_RESET;
            r_width  <= GRID_RESET;
            r_height <= GRID_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COUNT:  r_count  <= i_cfg_data[COUNTW-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    coc_front #(
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_front (
        .push          (push),
        .full          (full),
        .i_operation   (i_operation),
        .i_slot        (i_slot),
        .i_center_col  (i_center_col),
        .i_center_row  (i_center_row),
        .i_radius      (i_radius),
        .i_clearance   (i_clearance),
        .i_cell_col    (i_cell_col),
        .i_cell_row    (i_cell_row),
        .i_grid_width  (r_width),
        .i_grid_height (r_height),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_cmd         (w_cmd_in)
    );

    coc_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_cmd   (w_cmd_out)
    );

    coc_back #(
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (w_q_empty),
        .o_q_pop          (w_q_pop),
        .i_cmd            (w_cmd_out),
        .i_obstacle_count (r_count),
        .o_res            (w_res),
        .i_res_ready      (w_res_ready)
    );

    // Output register; a new result may load in the cycle the old one pops.
    assign w_res_ready = !r_out_vld || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_ready) begin
            r_out_vld <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res.valid) begin
            r_out_cost    <= w_res.cost;
            r_out_outside <= w_res.outside;
        end
    end

    assign empty         = !r_out_vld;
    assign o_cost        = r_out_cost;
    assign o_outside_map = r_out_outside;

endmodule

@@ hdl/coc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module coc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/coc_front.sv @@
// ----------------------------------------------------------------------------
// Circle obstacle cost classifier front end
// Accepts input items, sorts them into table writes and cell queries, flags
// cells outside the map and checks the slot range before queuing a command.
// ----------------------------------------------------------------------------
module coc_front #(
    parameter int MAX_OBSTACLES = 8
) (
    input  logic                              push,
    output logic                              full,
    input  logic                              i_operation,
    input  logic [coc_pkg::SLOTW-1:0]         i_slot,
    input  logic signed [coc_pkg::CW-1:0]     i_center_col,
    input  logic signed [coc_pkg::CW-1:0]     i_center_row,
    input  logic [coc_pkg::RW-1:0]            i_radius,
    input  logic [coc_pkg::RW-1:0]            i_clearance,
    input  logic [coc_pkg::CELLW-1:0]         i_cell_col,
    input  logic [coc_pkg::CELLW-1:0]         i_cell_row,
    input  logic [coc_pkg::DIMW-1:0]          i_grid_width,
    input  logic [coc_pkg::DIMW-1:0]          i_grid_height,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output coc_pkg::t_cmd                     o_cmd
);
    import coc_pkg::*;

    localparam int GCW = ($clog2(GRID_DIM + 1) > DIMW) ? $clog2(GRID_DIM + 1) : DIMW;
    localparam int SCW = ($clog2(MAX_OBSTACLES + 1) > SLOTW) ?
                         $clog2(MAX_OBSTACLES + 1) : SLOTW;

    logic [GCW-1:0] w_width;
    logic [GCW-1:0] w_height;

    // Transfer takes place whenever the command queue has room.
    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full;

    // Clamp the map size to the largest supported grid.
    always_comb begin
        w_width  = (GCW'(i_grid_width) > GCW'(GRID_DIM)) ? GCW'(GRID_DIM) : GCW'(i_grid_width);
        w_height = (GCW'(i_grid_height) > GCW'(GRID_DIM)) ?
                   GCW'(GRID_DIM) : GCW'(i_grid_height);
    end

    // Build the queued command.
    always_comb begin
        o_cmd.op                = t_op'(i_operation);
        o_cmd.slot              = i_slot;
        o_cmd.slot_ok           = SCW'(i_slot) < SCW'(MAX_OBSTACLES);
        o_cmd.obst.center_col   = i_center_col;
        o_cmd.obst.center_row   = i_center_row;
        o_cmd.obst.radius       = i_radius;
        o_cmd.obst.clearance    = i_clearance;
        o_cmd.col               = i_cell_col;
        o_cmd.row               = i_cell_row;
        o_cmd.outside           = (GCW'(i_cell_col) >= w_width) ||
                                  (GCW'(i_cell_row) >= w_height);
    end

endmodule

@@ hdl/coc_fifo.sv @@
// ----------------------------------------------------------------------------
// Circle obstacle cost classifier command queue
// Two-entry queue that decouples the front end from the scan back end.
// ----------------------------------------------------------------------------
module coc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  coc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output coc_pkg::t_cmd o_cmd
);
    import coc_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    t_cmd           r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [NW-1:0]  r_cnt;
    logic [NW-1:0]  n_cnt;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

@@ hdl/coc_back.sv @@
// ----------------------------------------------------------------------------
// Circle obstacle cost classifier back end
// Executes queued commands: writes table slots, and for a cell query scans
// the obstacle table one slot per cycle through a four-stage test pipeline.
// ----------------------------------------------------------------------------
module coc_back #(
    parameter int MAX_OBSTACLES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    output logic                        o_q_pop,
    input  coc_pkg::t_cmd               i_cmd,
    input  logic [coc_pkg::COUNTW-1:0]  i_obstacle_count,
    output coc_pkg::t_res               o_res,
    input  logic                        i_res_ready
);
    import coc_pkg::*;

    localparam int AW   = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CMPW = ($clog2(MAX_OBSTACLES + 1) > COUNTW) ?
                          $clog2(MAX_OBSTACLES + 1) : COUNTW;
    localparam logic signed [BW-1:0] NEG_CELL = BW'(-(2 ** FRAC_BITS));

    t_bstate r_state;
    t_bstate n_state;

    logic [COUNTW-1:0]        w_n;
    logic                     w_we;
    logic                     w_rd_en;
    logic                     w_pop_cls;
    t_obst                    w_rd;
    logic [OBSTW-1:0]         w_rdata;

    logic [COUNTW-1:0]        r_s;
    logic [CELLW-1:0]         r_col;
    logic [CELLW-1:0]         r_row;
    logic signed [COSTW-1:0]  r_cost;
    logic                     r_outside;

    logic                     r_vld1;
    logic                     r_vld2;
    logic                     r_vld3;

    logic signed [DXW-1:0]    w_cpos;
    logic signed [DXW-1:0]    w_rpos;
    logic signed [DXW-1:0]    r_dx;
    logic signed [DXW-1:0]    r_dy;
    logic [RW-1:0]            r_r;
    logic [RW:0]              r_rm;
    logic                     r_box2;

    logic signed [SQW-1:0]    w_dx_sq;
    logic signed [SQW-1:0]    w_dy_sq;
    logic [SQW-1:0]           r_dx2;
    logic [SQW-1:0]           r_dy2;
    logic [2*RW-1:0]          r_r2;
    logic [2*RW+1:0]          r_rm2;
    logic                     r_box3;

    logic [D2W-1:0]           w_d2;

    // Truncated, clamped box test along one axis for a cell inside the map.
    function automatic logic box_ok(logic [CELLW-1:0] pos,
                                    logic signed [CW-1:0] center,
                                    logic [RW-1:0] r);
        logic signed [BW-1:0] v_lo;
        logic signed [BW-1:0] v_hi;
        logic signed [BW-1:0] c;
        logic                 lo_ok;
        logic                 hi_ok;
        v_lo  = BW'(center) - $signed(BW'(r));
        v_hi  = BW'(center) + $signed(BW'(r));
        c     = $signed(BW'(pos));
        lo_ok = v_lo[BW-1] || (c >= (v_lo >>> FRAC_BITS));
        if (v_hi[BW-1]) begin
            hi_ok = (pos == '0) && (v_hi > NEG_CELL);
        end else begin
            hi_ok = c <= (v_hi >>> FRAC_BITS);
        end
        return lo_ok && hi_ok;
    endfunction

    // Number of slots to scan.
    always_comb begin
        w_n = (CMPW'(i_obstacle_count) > CMPW'(MAX_OBSTACLES)) ?
              COUNTW'(MAX_OBSTACLES) : i_obstacle_count;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty && (i_cmd.op == OP_CLASSIFY)) begin
                    if (i_cmd.outside || (w_n == '0)) begin
                        n_state = B_OUT;
                    end else begin
                        n_state = B_SCAN;
                    end
                end
            end
            B_SCAN: begin
                if (r_s == (w_n - COUNTW'(1))) begin
                    n_state = B_DRAIN;
                end
            end
            B_DRAIN: begin
                if (!r_vld1 && !r_vld2 && !r_vld3) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (i_res_ready) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_q_pop     = (r_state == B_IDLE) && !i_q_empty;
        w_pop_cls   = o_q_pop && (i_cmd.op == OP_CLASSIFY);
        w_we        = o_q_pop && (i_cmd.op == OP_WRITE) && i_cmd.slot_ok;
        w_rd_en     = (r_state == B_SCAN);
        o_res.valid = (r_state == B_OUT);
        o_res.cost  = r_cost;
        o_res.outside = r_outside;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_vld1  <= 1'b0;
            r_vld2  <= 1'b0;
            r_vld3  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld1  <= w_rd_en;
            r_vld2  <= r_vld1;
            r_vld3  <= r_vld2;
        end
    end

    // Obstacle table.
    coc_ram #(
        .WIDTH (OBSTW),
        .DEPTH (MAX_OBSTACLES),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_cmd.slot)),
        .i_wdata (i_cmd.obst),
        .i_raddr (AW'(r_s)),
        .o_rdata (w_rdata)
    );

    assign w_rd = t_obst'(w_rdata);

    // Query context and scan counter.
    always_ff @(posedge i_clk) begin
        if (w_pop_cls) begin
            r_col     <= i_cmd.col;
            r_row     <= i_cmd.row;
            r_outside <= i_cmd.outside;
            r_s       <= '0;
        end else if (w_rd_en) begin
            r_s <= r_s + COUNTW'(1);
        end
    end

    // Stage A: box test and offsets from the center.
    always_comb begin
        w_cpos = $signed(DXW'(r_col)) <<< FRAC_BITS;
        w_rpos = $signed(DXW'(r_row)) <<< FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= w_cpos - DXW'(w_rd.center_col);
        r_dy   <= w_rpos - DXW'(w_rd.center_row);
        r_r    <= w_rd.radius;
        r_rm   <= (RW + 1)'(w_rd.radius) + (RW + 1)'(w_rd.clearance);
        r_box2 <= box_ok(r_col, w_rd.center_col, w_rd.radius) &&
                  box_ok(r_row, w_rd.center_row, w_rd.radius);
    end

    // Stage B: squares.
    always_comb begin
        w_dx_sq = r_dx * r_dx;
        w_dy_sq = r_dy * r_dy;
    end

    always_ff @(posedge i_clk) begin
        r_dx2  <= $unsigned(w_dx_sq);
        r_dy2  <= $unsigned(w_dy_sq);
        r_r2   <= r_r * r_r;
        r_rm2  <= r_rm * r_rm;
        r_box3 <= r_box2;
    end

    // Stage C: distance compare; a later slot that hits overrides earlier ones.
    assign w_d2 = D2W'(r_dx2) + D2W'(r_dy2);

    always_ff @(posedge i_clk) begin
        if (w_pop_cls) begin
            r_cost <= COST_UNKNOWN;
        end else if (r_vld3 && r_box3) begin
            if (w_d2 <= D2W'(r_r2)) begin
                r_cost <= COST_LETHAL;
            end else if (w_d2 <= D2W'(r_rm2)) begin
                r_cost <= COST_MARGIN;
            end
        end
    end

endmodule

@@ hdl/coc_checker.sv @@
// ----------------------------------------------------------------------------
// Circle obstacle cost classifier port checker
// Watches the top-level ports for reset behavior and result consistency.
// ----------------------------------------------------------------------------
module coc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              full,
    input logic                              empty,
    input logic                              pop,
    input logic signed [coc_pkg::COSTW-1:0]  o_cost,
    input logic                              o_outside_map
);
    import coc_pkg::*;

    // Reset leaves no result waiting and room for input.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    // A waiting result holds until it is popped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_cost) && $stable(o_outside_map))
        else $error("result changed while stalled");

    // A cell outside the map always reports unknown cost.
    a_outside_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_outside_map |-> o_cost == COST_UNKNOWN)
        else $error("outside cell with known cost");

    // Only the three cost codes appear.
    a_cost_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_cost == COST_UNKNOWN || o_cost == COST_MARGIN ||
                    o_cost == COST_LETHAL))
        else $error("illegal cost code");

endmodule

bind circle_obstacle_cost_classifier_core coc_checker u_coc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_cost        (o_cost),
    .o_outside_map (o_outside_map)
);
